// File: hdl/rebq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the quadrature transition table
// for the rotary encoder and button qualifier; no dependencies
package rebq_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int TIME_WIDTH_DEFAULT  = 16;

    localparam int MS_WIDTH  = 16;
    localparam int CFG_WIDTH = 16;

    // register indexes on the write port
    localparam logic REG_LONG_PRESS = 1'b0;
    localparam logic REG_REBOUND    = 1'b1;

    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] REBOUND_RESET    = 16'd200;

    // {previous phase, current phase} codes
    localparam logic [3:0] TRANS_FWD_0  = 4'b1101;
    localparam logic [3:0] TRANS_FWD_1  = 4'b0100;
    localparam logic [3:0] TRANS_FWD_2  = 4'b0010;
    localparam logic [3:0] TRANS_FWD_3  = 4'b1011;
    localparam logic [3:0] TRANS_BACK_0 = 4'b1110;
    localparam logic [3:0] TRANS_BACK_1 = 4'b0111;
    localparam logic [3:0] TRANS_BACK_2 = 4'b0001;
    localparam logic [3:0] TRANS_BACK_3 = 4'b1000;

    typedef enum logic [1:0] {
        MOVE_NONE,
        MOVE_FWD,
        MOVE_BACK
    } move_t;

    typedef struct packed {
        logic                pin_a;
        logic                pin_b;
        logic                button_level;
        logic [MS_WIDTH-1:0] elapsed_ms;
    } tick_t;

    typedef struct packed {
        logic turn_up;
        logic turn_down;
        logic short_press;
        logic long_press;
    } result_t;

    typedef struct packed {
        logic up;
        logic down;
    } turn_t;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } press_t;

    function automatic move_t phase_move(input logic [3:0] trans);
        move_t mv;
        unique case (trans)
            TRANS_FWD_0, TRANS_FWD_1, TRANS_FWD_2, TRANS_FWD_3:
                mv = MOVE_FWD;
            TRANS_BACK_0, TRANS_BACK_1, TRANS_BACK_2, TRANS_BACK_3:
                mv = MOVE_BACK;
            default:
                mv = MOVE_NONE;
        endcase
        return mv;
    endfunction

endpackage

// File: hdl/rebq_encoder.sv
`timescale 1ns / 1ps
// quadrature step counter and detent detector
// depends on rebq_pkg
module rebq_encoder
    import rebq_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  pin_a,
    input  logic  pin_b,
    output turn_t turn
);

    localparam int QW = COUNT_WIDTH - 2;

    logic [1:0]             prev_phase_reg;
    logic [1:0]             prev_phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] reported_reg;
    logic [COUNT_WIDTH-1:0] reported_next;
    logic [QW-1:0]          quot_diff;
    move_t                  mv;

    always_comb
    begin
        prev_phase_next = {pin_a, pin_b};
        mv = phase_move({prev_phase_reg, pin_a, pin_b});
        unique case (mv)
            MOVE_FWD:  count_next = count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            MOVE_BACK: count_next = count_reg - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            default:   count_next = count_reg;
        endcase

        // quotient difference wraps, its top bit gives the direction
        quot_diff = count_next[COUNT_WIDTH-1:2] - reported_reg[COUNT_WIDTH-1:2];
        turn.up   = (quot_diff != '0) && quot_diff[QW-1];
        turn.down = (quot_diff != '0) && !quot_diff[QW-1];
        reported_next = (quot_diff != '0) ? count_next : reported_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg <= '0;
            count_reg      <= '0;
            reported_reg   <= '0;
        end
        else if (step)
        begin
            prev_phase_reg <= prev_phase_next;
            count_reg      <= count_next;
            reported_reg   <= reported_next;
        end
    end

endmodule

// File: hdl/rebq_button.sv
`timescale 1ns / 1ps
// button hold timer, long/short press qualifier and rebound lockout
// depends on rebq_pkg
module rebq_button
    import rebq_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 button_level,
    input  logic [MS_WIDTH-1:0]  elapsed_ms,
    input  logic [CFG_WIDTH-1:0] long_press_ms,
    input  logic [CFG_WIDTH-1:0] rebound_ms,
    output press_t               press
);

    localparam int BASE_W = (TIME_WIDTH > MS_WIDTH) ? TIME_WIDTH : MS_WIDTH;
    localparam int WIDE_W = BASE_W + 1;
    localparam logic [WIDE_W-1:0] TIME_MAX_W =
        {{(WIDE_W-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

    logic                  seen_reg;
    logic                  seen_next;
    logic [TIME_WIDTH-1:0] held_reg;
    logic [TIME_WIDTH-1:0] held_next;
    logic                  suppress_reg;
    logic                  suppress_next;
    logic [TIME_WIDTH-1:0] lockout_reg;
    logic [TIME_WIDTH-1:0] lockout_next;

    logic                  pressed;
    logic [WIDE_W-1:0]     elapsed_w;
    logic [WIDE_W-1:0]     held_sum;
    logic [TIME_WIDTH-1:0] held_sat;
    logic [WIDE_W-1:0]     long_w;
    logic [TIME_WIDTH-1:0] long_lim;
    logic [WIDE_W-1:0]     rebound_w;
    logic [TIME_WIDTH-1:0] rebound_lim;
    logic [TIME_WIDTH-1:0] lockout_mid;
    logic [WIDE_W-1:0]     lockout_w;

    always_comb
    begin
        pressed   = !button_level;
        elapsed_w = {{(WIDE_W-MS_WIDTH){1'b0}}, elapsed_ms};

        // register values clamped to the timer range
        long_w    = {{(WIDE_W-CFG_WIDTH){1'b0}}, long_press_ms};
        long_lim  = (long_w > TIME_MAX_W) ? {TIME_WIDTH{1'b1}} : long_w[TIME_WIDTH-1:0];
        rebound_w = {{(WIDE_W-CFG_WIDTH){1'b0}}, rebound_ms};
        rebound_lim = (rebound_w > TIME_MAX_W) ? {TIME_WIDTH{1'b1}}
                                               : rebound_w[TIME_WIDTH-1:0];

        held_sum = {{(WIDE_W-TIME_WIDTH){1'b0}}, held_reg} + elapsed_w;
        held_sat = (held_sum > TIME_MAX_W) ? {TIME_WIDTH{1'b1}} : held_sum[TIME_WIDTH-1:0];

        held_next         = held_reg;
        suppress_next     = suppress_reg;
        lockout_mid       = lockout_reg;
        press.long_press  = 1'b0;
        press.short_press = 1'b0;

        if (pressed && !suppress_reg)
        begin
            held_next = held_sat;
            if (held_sat >= long_lim)
            begin
                suppress_next    = 1'b1;
                press.long_press = 1'b1;
            end
        end

        // release edge
        if (seen_reg && !pressed)
        begin
            if (suppress_next)
            begin
                suppress_next = 1'b0;
            end
            else if (lockout_reg == '0)
            begin
                press.short_press = 1'b1;
                lockout_mid       = rebound_lim;
            end
            held_next = '0;
        end
        seen_next = pressed;

        lockout_w = {{(WIDE_W-TIME_WIDTH){1'b0}}, lockout_mid};
        if (lockout_w > elapsed_w)
        begin
            lockout_next = lockout_mid - elapsed_w[TIME_WIDTH-1:0];
        end
        else
        begin
            lockout_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            held_reg     <= '0;
            suppress_reg <= 1'b0;
            lockout_reg  <= '0;
        end
        else if (step)
        begin
            seen_reg     <= seen_next;
            held_reg     <= held_next;
            suppress_reg <= suppress_next;
            lockout_reg  <= lockout_next;
        end
    end

endmodule

// File: hdl/rotary_encoder_and_button_qualifier.sv
`timescale 1ns / 1ps
// Rotary encoder and button qualifier, top level.
// Input channel tick/tick_valid/tick_ready carries one sample per transfer:
// the two quadrature pins, the raw active-low button level and the
// milliseconds since the previous sample. Output channel
// result/result_valid/result_ready returns exactly one result per sample
// with turn_up, turn_down, short_press and long_press flags.
// A sample lands in an input register; from there one pass of table
// lookup, add, compare and subtract updates the encoder and button state
// and fills the result register. result_valid rises once the sample has
// passed the input and result registers; throughput is one sample per
// cycle, limited only by the result register draining.
// When result_ready is low the result register holds; the input register
// still takes one more sample, then tick_ready drops until the result
// is taken. Reset (rst_n low, asynchronous) clears the step count, hold
// timer, lockout and both pipeline valids; long_press_ms returns to 1000
// and rebound_ms to 200. Registers are written through write_en/
// write_index/write_data with no wait; the user must write them only
// while no sample is in flight, which the block itself does not enforce.
// depends on rebq_pkg, rebq_encoder, rebq_button
module rotary_encoder_and_button_qualifier
    import rebq_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_valid,
    output logic                 tick_ready,
    input  tick_t                tick,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 write_en,
    input  logic                 write_index,
    input  logic [CFG_WIDTH-1:0] write_data
);

    logic                 in_valid_reg;
    tick_t                in_data_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    result_t              out_data_next;
    logic [CFG_WIDTH-1:0] long_press_reg;
    logic [CFG_WIDTH-1:0] rebound_reg;
    logic                 advance;
    turn_t                turn;
    press_t               press;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign tick_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    rebq_encoder #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_encoder (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .pin_a (in_data_reg.pin_a),
        .pin_b (in_data_reg.pin_b),
        .turn  (turn)
    );

    rebq_button #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_button (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .button_level  (in_data_reg.button_level),
        .elapsed_ms    (in_data_reg.elapsed_ms),
        .long_press_ms (long_press_reg),
        .rebound_ms    (rebound_reg),
        .press         (press)
    );

    always_comb
    begin
        out_data_next.turn_up     = turn.up;
        out_data_next.turn_down   = turn.down;
        out_data_next.short_press = press.short_press;
        out_data_next.long_press  = press.long_press;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RESET;
            rebound_reg    <= REBOUND_RESET;
        end
        else if (write_en)
        begin
            unique case (write_index)
                REG_LONG_PRESS: long_press_reg <= write_data;
                REG_REBOUND:    rebound_reg    <= write_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_ready)
            begin
                in_valid_reg <= tick_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            in_data_reg <= tick;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: test/tb_rotary_encoder_and_button_qualifier.sv
`timescale 1ns / 1ps
// testbench for rotary_encoder_and_button_qualifier: directed ticks, then random
// encoder walks and button presses under several register settings, checked per flag
// depends on rebq_pkg and the rotary_encoder_and_button_qualifier rtl
module tb_rotary_encoder_and_button_qualifier;
    import rebq_pkg::*;

    localparam int CW             = COUNT_WIDTH_DEFAULT;
    localparam int TW             = TIME_WIDTH_DEFAULT;
    localparam int N_SETTINGS     = 6;
    localparam int PHASE_TICKS    = 190;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 8;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // flag patterns for the hand-checked rows
    localparam result_t EV_NONE  = 4'b0000;
    localparam result_t EV_UP    = 4'b1000;
    localparam result_t EV_DOWN  = 4'b0100;
    localparam result_t EV_SHORT = 4'b0010;
    localparam result_t EV_LONG  = 4'b0001;

    // forward walk 00 -> 10 -> 11 -> 01, and the walk position of each phase
    localparam logic [7:0] GRAY_WALK    = 8'b01_11_10_00;
    localparam logic [7:0] POS_OF_PHASE = 8'b10_01_11_00;

    typedef struct {
        tick_t   t;
        bit      pinned;
        result_t want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 tick_valid;
    logic                 tick_ready;
    tick_t                tick;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;
    logic                 write_en;
    logic                 write_index;
    logic [CFG_WIDTH-1:0] write_data;

    // travels with the tick so the monitor knows whether a row carries a typed result
    bit      row_pinned;
    result_t row_result;

    // predictor state and registers
    logic [CFG_WIDTH-1:0] long_press_cfg;
    logic [CFG_WIDTH-1:0] rebound_cfg;
    logic [1:0]           last_phase;
    logic [CW-1:0]        steps;
    logic [CW-1:0]        shown_steps;
    logic                 was_pressed;
    logic [TW-1:0]        hold_ms;
    logic                 swallow_release;
    logic [TW-1:0]        lockout_ms;

    result_t   due_results [$];
    plan_row_t tick_plan [$];

    // random walk state
    int gen_pos;
    int gen_dir;
    bit btn_down;
    int btn_left;

    int items_sent;
    int results_seen;
    int mismatches;
    int idle_cycles;
    int ups_seen;
    int downs_seen;
    int shorts_seen;
    int longs_seen;

    rotary_encoder_and_button_qualifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .write_en     (write_en),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic result_t qualify_tick(input tick_t t);
        result_t       r;
        logic [1:0]    phase;
        logic          pressed;
        move_t         mv;
        logic [CW-3:0] quot_diff;
        logic [TW:0]   hold_sum;
        r       = EV_NONE;
        phase   = {t.pin_a, t.pin_b};
        pressed = ~t.button_level;
        case ({last_phase, phase})
            TRANS_FWD_0, TRANS_FWD_1, TRANS_FWD_2, TRANS_FWD_3:
                mv = MOVE_FWD;
            TRANS_BACK_0, TRANS_BACK_1, TRANS_BACK_2, TRANS_BACK_3:
                mv = MOVE_BACK;
            default:
                mv = MOVE_NONE;
        endcase
        if (mv == MOVE_FWD)
            steps = steps + 1'b1;
        else if (mv == MOVE_BACK)
            steps = steps - 1'b1;
        last_phase = phase;

        // detent direction is the sign of the wrapped quotient difference
        quot_diff = steps[CW-1:2] - shown_steps[CW-1:2];
        if (quot_diff != '0)
        begin
            r.turn_up   = quot_diff[CW-3];
            r.turn_down = ~quot_diff[CW-3];
            shown_steps = steps;
        end

        if (pressed && !swallow_release)
        begin
            hold_sum = {1'b0, hold_ms} + t.elapsed_ms;
            hold_ms  = hold_sum[TW] ? '1 : hold_sum[TW-1:0];
            if (hold_ms >= long_press_cfg)
            begin
                swallow_release = 1'b1;
                r.long_press    = 1'b1;
            end
        end

        if (was_pressed != pressed)
        begin
            if (!pressed)
            begin
                if (swallow_release)
                    swallow_release = 1'b0;
                else if (lockout_ms == '0)
                begin
                    r.short_press = 1'b1;
                    lockout_ms    = rebound_cfg;
                end
                hold_ms = '0;
            end
            was_pressed = pressed;
        end

        if (lockout_ms != '0)
            lockout_ms = (lockout_ms > t.elapsed_ms) ? lockout_ms - t.elapsed_ms : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (write_en)
            begin
                if (write_index == REG_LONG_PRESS)
                    long_press_cfg = write_data;
                else
                    rebound_cfg = write_data;
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("turn_up", want.turn_up, result.turn_up);
                    check_field("turn_down", want.turn_down, result.turn_down);
                    check_field("short_press", want.short_press, result.short_press);
                    check_field("long_press", want.long_press, result.long_press);
                end
                ups_seen    += result.turn_up;
                downs_seen  += result.turn_down;
                shorts_seen += result.short_press;
                longs_seen  += result.long_press;
            end
            if (tick_valid && tick_ready)
            begin
                want = qualify_tick(tick);
                due_results.push_back(row_pinned ? row_result : want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && tick_ready) || (result_valid && result_ready) || write_en)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   idle_cycles, due_results.size());
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : receiver
        int  len;
        int  r;
        bit  held_off;
        held_off     = 1'b0;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= HOLD_AT)
            begin
                // long hold-off so the input side backs up and stalls
                held_off = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    result_ready <= 1'b1;
                    len = $urandom_range(50, 150);
                end
                else if (r < 70)
                begin
                    result_ready <= 1'b1;
                    len = $urandom_range(1, 4);
                end
                else if (r < 95)
                begin
                    result_ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    result_ready <= 1'b0;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TW-1:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return TW'($urandom_range(0, 30));
        else if (r < 85)
            return TW'($urandom_range(0, 200));
        else if (r < 95)
            return TW'($urandom_range(0, 2000));
        return TW'($urandom_range(0, 65535));
    endfunction

    // mostly clean quadrature walks and press/release runs, with some noise
    function automatic tick_t next_tick();
        tick_t t;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            t.pin_a        = 1'($urandom_range(0, 1));
            t.pin_b        = 1'($urandom_range(0, 1));
            t.button_level = 1'($urandom_range(0, 1));
            t.elapsed_ms   = MS_WIDTH'($urandom_range(0, 65535));
            gen_pos        = int'(POS_OF_PHASE[{t.pin_a, t.pin_b}*2 +: 2]);
            btn_down       = ~t.button_level;
            return t;
        end
        if ($urandom_range(0, 99) < 10)
            gen_dir = -gen_dir;
        r = $urandom_range(0, 99);
        if (r < 70)
            gen_pos = (gen_pos + gen_dir) & 3;
        else if (r < 75)
            gen_pos = (gen_pos + 2) & 3;
        {t.pin_a, t.pin_b} = GRAY_WALK[gen_pos*2 +: 2];
        if (btn_left <= 0)
        begin
            btn_down = !btn_down;
            if (btn_down)
                btn_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(1, 4);
            else
                btn_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                       : $urandom_range(1, 3);
        end
        btn_left--;
        t.button_level = !btn_down;
        t.elapsed_ms   = pick_elapsed();
        return t;
    endfunction

    task automatic offer_tick(input tick_t t, input bit pinned, input result_t want,
                              input int gap);
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        row_pinned <= pinned;
        row_result <= want;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_WIDTH-1:0] long_ms,
                                 input logic [CFG_WIDTH-1:0] rebound_ms);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_en    <= 1'b1;
        write_index <= REG_LONG_PRESS;
        write_data  <= long_ms;
        @(posedge clk);
        write_index <= REG_REBOUND;
        write_data  <= rebound_ms;
        @(posedge clk);
        write_en <= 1'b0;
    endtask

    task automatic plan_row(input logic a, input logic b, input logic btn,
                            input logic [TW-1:0] el, input bit pinned, input result_t want);
        plan_row_t row;
        row.t.pin_a        = a;
        row.t.pin_b        = b;
        row.t.button_level = btn;
        row.t.elapsed_ms   = el;
        row.pinned         = pinned;
        row.want           = want;
        tick_plan.push_back(row);
    endtask

    initial
    begin : stimulus
        logic [CFG_WIDTH-1:0] long_set [N_SETTINGS];
        logic [CFG_WIDTH-1:0] rebound_set [N_SETTINGS];
        int                   p;
        int                   i;
        bit                   burst;

        rst_n       = 1'b0;
        tick_valid  = 1'b0;
        tick        = '0;
        row_pinned  = 1'b0;
        row_result  = EV_NONE;
        write_en    = 1'b0;
        write_index = REG_LONG_PRESS;
        write_data  = '0;

        long_press_cfg  = LONG_PRESS_RESET;
        rebound_cfg     = REBOUND_RESET;
        last_phase      = '0;
        steps           = '0;
        shown_steps     = '0;
        was_pressed     = 1'b0;
        hold_ms         = '0;
        swallow_release = 1'b0;
        lockout_ms      = '0;
        gen_pos         = 0;
        gen_dir         = 1;
        btn_down        = 1'b0;
        btn_left        = 3;

        long_set    = '{16'd50, 16'd1, 16'd65535, 16'd0, 16'd300, 16'd0};
        rebound_set = '{16'd30, 16'd0, 16'd65535, 16'd5, 16'd1000, 16'd0};
        long_set[N_SETTINGS-1]    = CFG_WIDTH'($urandom_range(1, 400));
        rebound_set[N_SETTINGS-1] = CFG_WIDTH'($urandom_range(0, 400));

        // register reset values: long press 1000, rebound 200
        plan_row(0, 0, 1, 0, 1, EV_NONE);      // idle after reset
        plan_row(1, 0, 1, 3, 1, EV_NONE);
        plan_row(1, 1, 1, 3, 1, EV_NONE);
        plan_row(0, 1, 1, 3, 1, EV_NONE);
        plan_row(0, 0, 1, 3, 1, EV_DOWN);      // four forward steps raise the quotient
        plan_row(0, 1, 1, 0, 1, EV_UP);
        plan_row(1, 1, 1, 0, 1, EV_NONE);
        plan_row(1, 0, 1, 0, 1, EV_NONE);
        plan_row(0, 0, 1, 0, 1, EV_NONE);
        plan_row(0, 1, 1, 0, 1, EV_UP);        // count wraps below zero
        plan_row(0, 0, 1, 0, 1, EV_DOWN);      // and back across the wrap
        plan_row(1, 1, 1, 0, 1, EV_NONE);      // both pins at once: skipped phase
        plan_row(0, 0, 1, 0, 1, EV_NONE);
        plan_row(0, 0, 0, 999, 1, EV_NONE);
        plan_row(0, 0, 0, 1, 1, EV_LONG);      // hold reaches the long press time
        plan_row(0, 0, 0, 16'hffff, 1, EV_NONE);
        plan_row(0, 0, 1, 0, 1, EV_NONE);      // release after long press is swallowed
        plan_row(0, 0, 0, 0, 1, EV_NONE);
        plan_row(0, 0, 1, 5, 1, EV_SHORT);
        plan_row(0, 0, 0, 100, 0, EV_NONE);
        plan_row(0, 0, 1, 0, 1, EV_NONE);      // release inside the rebound lockout
        plan_row(0, 0, 0, 95, 0, EV_NONE);
        plan_row(0, 0, 1, 0, 1, EV_SHORT);
        plan_row(1, 0, 0, 16'hffff, 0, EV_NONE); // step, press and saturating hold together
        plan_row(1, 1, 1, 0, 0, EV_NONE);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tick_plan[k])
            offer_tick(tick_plan[k].t, tick_plan[k].pinned, tick_plan[k].want, pick_gap());

        for (p = 0; p < N_SETTINGS; p++)
        begin
            apply_setting(long_set[p], rebound_set[p]);
            burst = 1'b0;
            for (i = 0; i < PHASE_TICKS; i++)
            begin
                if (i % 40 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                offer_tick(next_tick(), 1'b0, EV_NONE, burst ? 0 : pick_gap());
            end
        end

        wait_for_drain();
        repeat (END_CYCLES) @(posedge clk);

        $display("%0d ticks over %0d register settings, %0d results checked",
                 items_sent, N_SETTINGS + 1, results_seen);
        $display("flags seen: %0d up, %0d down, %0d short press, %0d long press",
                 ups_seen, downs_seen, shorts_seen, longs_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
hdl/rebq_pkg.sv
hdl/rebq_encoder.sv
hdl/rebq_button.sv
hdl/rotary_encoder_and_button_qualifier.sv
test/tb_rotary_encoder_and_button_qualifier.sv
